### rtl/core/fmrt_pkg.sv
// Shared types and constants for the floor match/remove table.
package fmrt_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_BITS  = 31;
  localparam int GROUP_SIZE  = 32;
  localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_CELLS   = NUM_GROUPS * GROUP_SIZE;
  localparam int IN_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;

  localparam logic       MODE_INSERT = 1'b0;
  localparam logic       MODE_QUERY  = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_NOMATCH  = 2'd3;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic   valid;
    logic   le;
    value_t value;
  } nbr_t;

endpackage

### rtl/core/floor_match_remove_table_core.sv
// Top level: sorted cell chain with insert and floor query/remove.
//
//  channel | direction | tdata                       | tuser
//  in      | slave     | [30:0] value                | [0] mode (0 insert, 1 query)
//  out     | master    | [30:0] matched_value        | [1:0] status
//
// An item is accepted (S_IDLE), then compared and shifted in every cell at once (S_EXEC),
// then the second level of the OR tree picks out the removed value (S_REDUCE).
// One item is in flight at a time; a new beat is taken the cycle after the
// previous result is loaded into the output register.
// Reset (synchronous) empties the table at once: every cell's valid bit clears.
// A stalled result holds in the output register; the next item runs its
// compare/shift and then waits until the output register frees.
module floor_match_remove_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fmrt_pkg::IN_DATA_W-1:0]  in_tdata,   // [30:0] value
  input  logic                            in_tuser,   // [0] mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fmrt_pkg::OUT_DATA_W-1:0] out_tdata,  // [30:0] matched_value
  output logic [1:0]                      out_tuser   // [1:0] status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } state_t;

  state_t           state_r;
  logic             mode_r;
  fmrt_pkg::value_t key_r;
  logic [1:0]       status_r;
  logic             out_tvalid_r;
  logic [1:0]       out_status_r;
  fmrt_pkg::value_t out_value_r;

  fmrt_pkg::op_t    op;
  logic             full;
  logic             found;
  logic             out_load;
  fmrt_pkg::value_t match_all;

  fmrt_pkg::nbr_t   nbr   [fmrt_pkg::CAPACITY];
  fmrt_pkg::value_t mask  [fmrt_pkg::PAD_CELLS];
  fmrt_pkg::value_t grp_or[fmrt_pkg::NUM_GROUPS];

  assign full  = nbr[fmrt_pkg::CAPACITY-1].valid;
  assign found = nbr[0].le;

  always_comb begin
    op = fmrt_pkg::OP_NONE;
    if (state_r == S_EXEC) begin
      if (mode_r == fmrt_pkg::MODE_QUERY) begin
        op = found ? fmrt_pkg::OP_REMOVE : fmrt_pkg::OP_NONE;
      end else begin
        op = full ? fmrt_pkg::OP_NONE : fmrt_pkg::OP_INSERT;
      end
    end
  end

  genvar g;
  genvar k;
  generate
    for (g = 0; g < fmrt_pkg::CAPACITY; g++) begin : g_cell
      fmrt_pkg::nbr_t left_n;
      fmrt_pkg::nbr_t right_n;
      if (g == 0) begin : g_first
        // head boundary counts as "at or below", so an insert lands here when smaller
        assign left_n = '{valid: 1'b1, le: 1'b1, value: '0};
      end else begin : g_mid_l
        assign left_n = nbr[g-1];
      end
      if (g == fmrt_pkg::CAPACITY - 1) begin : g_last
        assign right_n = '{valid: 1'b0, le: 1'b0, value: '0};
      end else begin : g_mid_r
        assign right_n = nbr[g+1];
      end
      fmrt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_i    (op),
        .key_i   (key_r),
        .left_i  (left_n),
        .right_i (right_n),
        .self_o  (nbr[g]),
        .mask_o  (mask[g])
      );
    end

    for (g = fmrt_pkg::CAPACITY; g < fmrt_pkg::PAD_CELLS; g++) begin : g_pad
      assign mask[g] = '0;
    end

    for (g = 0; g < fmrt_pkg::NUM_GROUPS; g++) begin : g_grp
      fmrt_pkg::value_t grp_mask [fmrt_pkg::GROUP_SIZE];
      for (k = 0; k < fmrt_pkg::GROUP_SIZE; k++) begin : g_sel
        assign grp_mask[k] = mask[g*fmrt_pkg::GROUP_SIZE + k];
      end
      fmrt_group u_group (
        .clk    (clk),
        .en_i   (state_r == S_EXEC),
        .mask_i (grp_mask),
        .or_o   (grp_or[g])
      );
    end
  endgenerate

  always_comb begin
    match_all = '0;
    for (int i = 0; i < fmrt_pkg::NUM_GROUPS; i++) begin
      match_all = match_all | grp_or[i];
    end
  end

  // result moves into the output register once it is empty or being drained
  assign out_load = (state_r == S_REDUCE) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r  <= in_tuser;
            key_r   <= in_tdata[fmrt_pkg::VALUE_BITS-1:0];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (mode_r == fmrt_pkg::MODE_QUERY) begin
            status_r <= found ? fmrt_pkg::ST_MATCH : fmrt_pkg::ST_NOMATCH;
          end else begin
            status_r <= full ? fmrt_pkg::ST_FULL : fmrt_pkg::ST_INSERTED;
          end
          state_r <= S_REDUCE;
        end
        S_REDUCE: begin
          if (out_load) begin
            out_status_r <= status_r;
            out_value_r  <= (status_r == fmrt_pkg::ST_MATCH) ? match_all : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(fmrt_pkg::OUT_DATA_W - fmrt_pkg::VALUE_BITS){1'b0}}, out_value_r};

endmodule

### rtl/core/fmrt_cell.sv
// One slot of the sorted chain: compare against the key, shift on insert or removal.
module fmrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  fmrt_pkg::op_t    op_i,
  input  fmrt_pkg::value_t key_i,
  input  fmrt_pkg::nbr_t   left_i,
  input  fmrt_pkg::nbr_t   right_i,
  output fmrt_pkg::nbr_t   self_o,
  output fmrt_pkg::value_t mask_o
);

  logic             valid_r;
  logic             valid_nxt;
  fmrt_pkg::value_t value_r;
  fmrt_pkg::value_t value_nxt;
  logic             le;

  assign le = valid_r && (value_r <= key_i);

  assign self_o = '{valid: valid_r, le: le, value: value_r};

  // last cell at or below the key is the floor match
  assign mask_o = (le && !right_i.le) ? value_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    case (op_i)
      fmrt_pkg::OP_INSERT: begin
        if (!le) begin
          if (left_i.le) begin
            valid_nxt = 1'b1;
            value_nxt = key_i;
          end else begin
            valid_nxt = left_i.valid;
            value_nxt = left_i.value;
          end
        end
      end
      fmrt_pkg::OP_REMOVE: begin
        if (!right_i.le) begin
          valid_nxt = right_i.valid;
          value_nxt = right_i.value;
        end
      end
      default: begin
        valid_nxt = valid_r;
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

endmodule

### rtl/core/fmrt_group.sv
// First level of the match tree: registered OR over one group of cell masks.
module fmrt_group (
  input  logic             clk,
  input  logic             en_i,
  input  fmrt_pkg::value_t mask_i [fmrt_pkg::GROUP_SIZE],
  output fmrt_pkg::value_t or_o
);

  fmrt_pkg::value_t or_r;
  fmrt_pkg::value_t or_nxt;

  always_comb begin
    or_nxt = '0;
    for (int i = 0; i < fmrt_pkg::GROUP_SIZE; i++) begin
      or_nxt = or_nxt | mask_i[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      or_r <= or_nxt;
    end
  end

  assign or_o = or_r;

endmodule

### bench/floor_match_remove_table_core_tb.sv
// Self-checking bench for floor_match_remove_table_core: floor query/remove multiset.
`timescale 1ns / 1ps

module floor_match_remove_table_core_tb;

  localparam fmrt_pkg::value_t VALUE_MAX   = '1;
  localparam int               CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0]       status;
    fmrt_pkg::value_t matched;
  } floor_result_t;

  // Multiset model plus the queue of results still owed by the block.
  class floor_table_scoreboard;
    fmrt_pkg::value_t held_values[$];
    floor_result_t    owed[$];
    int               errors;
    int               n_insert;
    int               n_drop;
    int               n_match;
    int               n_miss;
    int               peak;

    function int count();
      return held_values.size();
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function fmrt_pkg::value_t any_held();
      return held_values[$urandom_range(0, held_values.size() - 1)];
    endfunction

    function void note_item(logic mode, fmrt_pkg::value_t val);
      floor_result_t    res;
      int               best_idx;
      fmrt_pkg::value_t best;
      best_idx = -1;
      best     = '0;
      res      = '{status: fmrt_pkg::ST_INSERTED, matched: '0};
      if (mode == fmrt_pkg::MODE_INSERT) begin
        if (held_values.size() >= fmrt_pkg::CAPACITY) begin
          res.status = fmrt_pkg::ST_FULL;
          n_drop++;
        end else begin
          held_values = {held_values, val};
          n_insert++;
          if (held_values.size() > peak) peak = held_values.size();
        end
      end else begin
        foreach (held_values[i]) begin
          if (held_values[i] <= val && (best_idx < 0 || held_values[i] > best)) begin
            best_idx = i;
            best     = held_values[i];
          end
        end
        if (best_idx < 0) begin
          res.status = fmrt_pkg::ST_NOMATCH;
          n_miss++;
        end else begin
          held_values.delete(best_idx);
          res.status  = fmrt_pkg::ST_MATCH;
          res.matched = best;
          n_match++;
        end
      end
      owed = {owed, res};
    endfunction

    function void check_result(logic [1:0] status, fmrt_pkg::value_t matched);
      floor_result_t want;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed: status %0d matched_value %0d", status, matched);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (matched !== want.matched) begin
        $error("matched_value: expected %0d, got %0d", want.matched, matched);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [fmrt_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                            in_tuser  = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [fmrt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;

  floor_table_scoreboard sb = new;
  int                    burst_left = 0;
  int                    cycles = 0;

  floor_match_remove_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Bias towards small values so duplicates and near misses are common.
  function automatic fmrt_pkg::value_t pick_value();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return VALUE_MAX;
      2, 3, 4, 5: return fmrt_pkg::value_t'($urandom_range(0, 63));
      6, 7:       return fmrt_pkg::value_t'($urandom_range(0, 4095));
      default:    return fmrt_pkg::value_t'($urandom);
    endcase
  endfunction

  // Limits landing on, just above or just below a stored value, else a pick_value draw.
  function automatic fmrt_pkg::value_t query_limit();
    fmrt_pkg::value_t base;
    if (sb.count() > 0 && $urandom_range(0, 9) < 4) begin
      base = sb.any_held();
      case ($urandom_range(0, 2))
        0:       return base;
        1:       return (base == VALUE_MAX) ? base : base + 1'b1;
        default: return (base == '0) ? base : base - 1'b1;
      endcase
    end
    return pick_value();
  endfunction

  // Bursts of back-to-back beats with random idle gaps between them.
  task automatic drive_item(input logic mode, input fmrt_pkg::value_t val);
    int                             gap;
    logic [fmrt_pkg::IN_DATA_W-1:0] beat_data;
    beat_data                          = '0;
    beat_data[fmrt_pkg::VALUE_BITS-1:0] = val;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= beat_data;
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, val);
  endtask

  // Receiver: picks a new random stall style after each run of random length.
  initial begin
    int run_left;
    int style;
    run_left = 0;
    style    = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready)
        sb.check_result(out_tuser, out_tdata[fmrt_pkg::VALUE_BITS-1:0]);
      if (run_left == 0) begin
        style    = $urandom_range(0, 3);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      case (style)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (run_left % 4 == 0);
      endcase
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, duplicates, alternating bit patterns
    drive_item(fmrt_pkg::MODE_QUERY,  '0);
    drive_item(fmrt_pkg::MODE_QUERY,  VALUE_MAX);
    drive_item(fmrt_pkg::MODE_INSERT, '0);
    drive_item(fmrt_pkg::MODE_INSERT, VALUE_MAX);
    drive_item(fmrt_pkg::MODE_INSERT, 31'd1000);
    drive_item(fmrt_pkg::MODE_INSERT, 31'd1000);
    drive_item(fmrt_pkg::MODE_QUERY,  31'd999);
    drive_item(fmrt_pkg::MODE_QUERY,  31'd999);
    drive_item(fmrt_pkg::MODE_QUERY,  VALUE_MAX);
    drive_item(fmrt_pkg::MODE_QUERY,  VALUE_MAX);
    drive_item(fmrt_pkg::MODE_QUERY,  31'd1000);
    drive_item(fmrt_pkg::MODE_QUERY,  VALUE_MAX);
    drive_item(fmrt_pkg::MODE_INSERT, 31'h2AAA_AAAA);
    drive_item(fmrt_pkg::MODE_INSERT, 31'h5555_5555);
    drive_item(fmrt_pkg::MODE_QUERY,  31'h5555_5554);
    drive_item(fmrt_pkg::MODE_QUERY,  31'h5555_5555);
    drive_item(fmrt_pkg::MODE_INSERT, 31'd5);
    drive_item(fmrt_pkg::MODE_QUERY,  31'd4);
    drive_item(fmrt_pkg::MODE_QUERY,  31'd5);

    // mixed traffic
    repeat (550) begin
      if ($urandom_range(0, 99) < 55) drive_item(fmrt_pkg::MODE_INSERT, pick_value());
      else                            drive_item(fmrt_pkg::MODE_QUERY, query_limit());
    end

    // drain to empty, then probe the empty table again
    while (sb.count() > 0) begin
      case ($urandom_range(0, 9))
        0:             drive_item(fmrt_pkg::MODE_INSERT, pick_value());
        1, 2, 3, 4, 5: drive_item(fmrt_pkg::MODE_QUERY, VALUE_MAX);
        default:       drive_item(fmrt_pkg::MODE_QUERY, query_limit());
      endcase
    end
    drive_item(fmrt_pkg::MODE_QUERY, VALUE_MAX);
    drive_item(fmrt_pkg::MODE_QUERY, '0);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d inserts, %0d drops on a full table, %0d floor matches, %0d misses",
             sb.n_insert, sb.n_drop, sb.n_match, sb.n_miss);
    $display("Peak occupancy %0d of %0d entries, ended empty", sb.peak, fmrt_pkg::CAPACITY);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
